>>> rtl/keyboard_typematic_command_parser_macros.svh
// assertion macros for the keyboard typematic command parser
// used at the end of the top level; no other dependencies
`ifndef KEYBOARD_TYPEMATIC_COMMAND_PARSER_MACROS_SVH
`define KEYBOARD_TYPEMATIC_COMMAND_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define KTCP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ktcp assertion failed");

// next-cycle implication, disabled during reset
`define KTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ktcp assertion failed");

`endif

>>> rtl/ktcp_pkg.sv
// constants, scan code table and word tables of the typematic command parser
// no dependencies
package ktcp_pkg;

	localparam logic [7:0] TYPEMATIC_CMD = 8'hF3;
	localparam logic [4:0] RATE_RESET    = 5'd30;
	localparam logic [4:0] MAX_RATE      = 5'd31;
	localparam logic [3:0] WORD_LEN      = 4'd7;
	localparam logic [3:0] NO_DIGIT      = 4'd15;
	localparam logic [3:0] MAX_DELAY     = 4'd3;
	localparam logic [3:0] MAX_DIGIT     = 4'd9;

	// make code (low seven bits) to ascii character, zero when unmapped
	function automatic logic [7:0] char_of_code(input logic [6:0] code);
		logic [7:0] ch;
		ch = 8'd0;
		unique case (code)
			7'd16: ch = "q";
			7'd17: ch = "w";
			7'd18: ch = "e";
			7'd19: ch = "r";
			7'd20: ch = "t";
			7'd21: ch = "y";
			7'd22: ch = "u";
			7'd23: ch = "i";
			7'd24: ch = "o";
			7'd25: ch = "p";
			7'd30: ch = "a";
			7'd31: ch = "s";
			7'd32: ch = "d";
			7'd33: ch = "f";
			7'd34: ch = "g";
			7'd35: ch = "h";
			7'd36: ch = "j";
			7'd37: ch = "k";
			7'd38: ch = "l";
			7'd44: ch = "z";
			7'd45: ch = "x";
			7'd46: ch = "c";
			7'd47: ch = "v";
			7'd48: ch = "b";
			7'd49: ch = "n";
			7'd50: ch = "m";
			7'd2:  ch = "1";
			7'd3:  ch = "2";
			7'd4:  ch = "3";
			7'd5:  ch = "4";
			7'd6:  ch = "5";
			7'd7:  ch = "6";
			7'd8:  ch = "7";
			7'd9:  ch = "8";
			7'd10: ch = "9";
			7'd11: ch = "0";
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

	// expected character at a word position, chdelay or chspeed
	function automatic logic [7:0] word_char(input logic is_speed, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'd0;
		unique case (pos)
			3'd0: ch = "c";
			3'd1: ch = "h";
			3'd2: ch = is_speed ? "s" : "d";
			3'd3: ch = is_speed ? "p" : "e";
			3'd4: ch = is_speed ? "e" : "l";
			3'd5: ch = is_speed ? "e" : "a";
			3'd6: ch = is_speed ? "d" : "y";
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

	// decimal value of a character, NO_DIGIT when not a digit
	function automatic logic [3:0] digit_value(input logic [7:0] ch);
		logic [7:0] diff;
		diff = ch - 8'("0");
		if (ch >= 8'("0") && ch <= 8'("9")) begin
			return diff[3:0];
		end
		return NO_DIGIT;
	endfunction

endpackage

>>> rtl/keyboard_typematic_command_parser.sv
// keyboard typematic command parser, top level
// depends on ktcp_pkg and keyboard_typematic_command_parser_macros.svh
`include "keyboard_typematic_command_parser_macros.svh"

// usage:
// scan codes come in on scan_valid / scan_stall / scan_code, one beat per code.
// break codes are dropped; make codes are matched against "chdelay" + digit
// and "chspeed" + two digits. a complete valid command sends two beats on
// cmd_valid / cmd_stall: command_byte 0xF3 with last_byte 0, then the rate
// byte delay*32+rate with last_byte 1.
// a scan beat lands in the input register at its accepting edge and is
// parsed at the edge on which it leaves that register, which a busy result
// buffer can hold off; the 0xF3 beat shows on the output right after that
// edge, and the rate byte shows the cycle after 0xF3 is taken.
// throughput is one scan beat per cycle; the only limit is the two-beat
// result buffer: a command-completing code waits in the input register
// until the buffer holds no more than one beat that is being taken.
// codes that send nothing never wait, even while results are stalled.
// reset clears the match count, delay to 0 and rate to 30, and empties
// both the input register and the result buffer.
// while cmd_stall is high the pending beat holds steady; scan_stall rises
// only when a command-completing code is blocked by a busy result buffer.
module keyboard_typematic_command_parser
	import ktcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scan_code,
	output logic       cmd_valid,
	input  logic       cmd_stall,
	output logic [7:0] command_byte,
	output logic       last_byte
);

	// input register
	logic       valid_s1;
	logic [7:0] scan_code_s1;

	// parser state
	logic [3:0] typed_count_q;
	logic       word_is_speed_q;
	logic [3:0] first_digit_q;
	logic [1:0] delay_setting_q;
	logic [4:0] rate_setting_q;

	// result buffer: count of beats left, and the rate byte
	logic [1:0] out_cnt_q;
	logic [7:0] rate_byte_q;

	// next-state values
	logic [3:0] typed_count_n;
	logic       word_is_speed_n;
	logic [3:0] first_digit_n;
	logic [1:0] delay_setting_n;
	logic [4:0] rate_setting_n;
	logic       emit;
	logic [7:0] rate_byte_n;

	logic [7:0] ch;
	logic [3:0] dval;
	logic [6:0] speed_val;
	logic       scan_take;
	logic       cmd_take;
	logic       buf_free;
	logic       advance;

	assign scan_take = scan_valid && !scan_stall;
	assign cmd_take  = cmd_valid && !cmd_stall;
	// room for two beats after this edge
	assign buf_free  = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && cmd_take);
	assign advance   = valid_s1 && (!emit || buf_free);
	// hold the input only when the registered code cannot move on
	assign scan_stall = valid_s1 && !advance;

	assign ch        = char_of_code(scan_code_s1[6:0]);
	assign dval      = digit_value(ch);
	// first_digit*10 + digit, used only once both are checked to be at most nine
	assign speed_val = {first_digit_q, 3'b000} + {2'b00, first_digit_q, 1'b0} + {3'b000, dval};

	// parser next state
	always_comb begin
		typed_count_n   = typed_count_q;
		word_is_speed_n = word_is_speed_q;
		first_digit_n   = first_digit_q;
		delay_setting_n = delay_setting_q;
		rate_setting_n  = rate_setting_q;
		emit            = 1'b0;
		rate_byte_n     = {1'b0, delay_setting_q, rate_setting_q};
		if (!scan_code_s1[7]) begin
			unique case (typed_count_q) inside
				4'd0, 4'd1: begin
					typed_count_n = (ch == word_char(1'b0, typed_count_q[2:0]))
						? typed_count_q + 4'd1 : 4'd0;
				end
				4'd2: begin
					// third character picks the word
					if (ch == word_char(1'b0, 3'd2)) begin
						word_is_speed_n = 1'b0;
						typed_count_n   = 4'd3;
					end else if (ch == word_char(1'b1, 3'd2)) begin
						word_is_speed_n = 1'b1;
						typed_count_n   = 4'd3;
					end else begin
						typed_count_n = 4'd0;
					end
				end
				4'd3, 4'd4, 4'd5, 4'd6: begin
					typed_count_n = (ch == word_char(word_is_speed_q, typed_count_q[2:0]))
						? typed_count_q + 4'd1 : 4'd0;
				end
				WORD_LEN: begin
					if (word_is_speed_q) begin
						first_digit_n = dval;
						typed_count_n = 4'd8;
					end else begin
						typed_count_n = 4'd0;
						if (dval <= MAX_DELAY) begin
							delay_setting_n = dval[1:0];
							emit            = 1'b1;
							rate_byte_n     = {1'b0, dval[1:0], rate_setting_q};
						end
					end
				end
				4'd8: begin
					typed_count_n = 4'd0;
					if (word_is_speed_q && first_digit_q <= MAX_DIGIT && dval <= MAX_DIGIT
						&& speed_val <= {2'b00, MAX_RATE}) begin
						rate_setting_n = speed_val[4:0];
						emit           = 1'b1;
						rate_byte_n    = {1'b0, delay_setting_q, speed_val[4:0]};
					end
				end
				default: begin
					typed_count_n = 4'd0;
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_take) begin
			scan_code_s1 <= scan_code;
		end
	end

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			typed_count_q   <= 4'd0;
			word_is_speed_q <= 1'b0;
			delay_setting_q <= 2'd0;
			rate_setting_q  <= RATE_RESET;
		end else if (advance) begin
			typed_count_q   <= typed_count_n;
			word_is_speed_q <= word_is_speed_n;
			delay_setting_q <= delay_setting_n;
			rate_setting_q  <= rate_setting_n;
		end
	end

	// first speed digit, always written before it is read
	always_ff @(posedge clk) begin
		if (advance) begin
			first_digit_q <= first_digit_n;
		end
	end

	// result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (advance && emit) begin
			out_cnt_q <= 2'd2;
		end else if (cmd_take) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			rate_byte_q <= rate_byte_n;
		end
	end

	assign cmd_valid    = (out_cnt_q != 2'd0);
	assign last_byte    = (out_cnt_q == 2'd1);
	assign command_byte = (out_cnt_q == 2'd2) ? TYPEMATIC_CMD : rate_byte_q;

	// a parsed command always opens with the 0xF3 beat
	`KTCP_ASSERT_NEXT(a_cmd_first, clk, arst_n, advance && emit,
		cmd_valid && !last_byte && command_byte == TYPEMATIC_CMD)
	// after the rate beat goes out, the buffer is empty or holds a fresh pair
	`KTCP_ASSERT_NEXT(a_rate_last, clk, arst_n, cmd_take && last_byte,
		out_cnt_q == 2'd0 || out_cnt_q == 2'd2)
	// match count never runs past the second speed digit, beat count never reaches three
	`KTCP_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1,
		typed_count_q <= 4'd8 && out_cnt_q != 2'd3)

endmodule
